[hdl/bfd_pkg.sv]
// Shared constants and types for the bracket frame deframer.
package bfd_pkg;

  localparam int FRAME_BYTES_DEF = 16;
  localparam int MIN_W = 4;

  localparam logic [MIN_W-1:0] MIN_BODY_RST = 4'd13;

  localparam logic [7:0] OPEN_BRACKET  = 8'h5B;
  localparam logic [7:0] CLOSE_BRACKET = 8'h5D;
  localparam logic [7:0] LOWER_A       = 8'd97;
  localparam logic [7:0] LOWER_Z       = 8'd122;
  localparam logic [7:0] CASE_OFFSET   = 8'd32;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } bfd_state_t;

  // controller -> datapath
  typedef struct packed {
    logic in_take;
    logic start_emit;
    logic rd_en;
    logic out_pop;
  } bfd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic close_ok;
    logic rd_final;
    logic out_valid;
  } bfd_sts_t;

endpackage

[hdl/bfd_if.sv]
// Valid/ready channel interfaces for received bytes and frame bytes.
interface bfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface bfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

[hdl/bfd_datapath.sv]
// Frame store, collect counters, configuration register and output register.
module bfd_datapath #(
  parameter int FRAME_BYTES = bfd_pkg::FRAME_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [bfd_pkg::MIN_W-1:0] cfg_wr_data,
  input  logic [7:0]              in_byte,
  input  bfd_pkg::bfd_cmd_t       cmd,
  output bfd_pkg::bfd_sts_t       sts,
  output logic                    out_valid,
  output logic [7:0]              out_byte,
  output logic                    out_last
);
  import bfd_pkg::*;

  localparam int IW = $clog2(FRAME_BYTES);
  localparam logic [IW-1:0] HELD_MAX = IW'(FRAME_BYTES - 1);

  logic [MIN_W-1:0] min_r;
  logic             in_frame_r, in_frame_nxt;
  logic [IW-1:0]    held_r, held_nxt;
  logic [IW-1:0]    rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]    last_idx_r, last_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  logic [7:0]       mem [FRAME_BYTES];
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [7:0]       wr_data;

  logic             is_open, is_close, enough, rd_final;
  logic [7:0]       up_byte;

  assign is_open  = (in_byte == OPEN_BRACKET);
  assign is_close = (in_byte == CLOSE_BRACKET);
  assign enough   = ({{MIN_W{1'b0}}, held_r} >= {{IW{1'b0}}, min_r});
  assign rd_final = (rd_idx_r == last_idx_r);
  assign up_byte  = ((in_byte >= LOWER_A) && (in_byte <= LOWER_Z)) ?
                    (in_byte - CASE_OFFSET) : in_byte;

  assign sts.close_ok  = is_close && in_frame_r && enough;
  assign sts.rd_final  = rd_final;
  assign sts.out_valid = out_valid_r;

  // collect: frame tracking and store writes
  always_comb begin
    in_frame_nxt = in_frame_r;
    held_nxt     = held_r;
    wr_en        = 1'b0;
    wr_addr      = held_r;
    wr_data      = in_byte;
    if (cmd.in_take) begin
      if (is_open) begin
        wr_en        = 1'b1;
        wr_addr      = '0;
        held_nxt     = IW'(1);
        in_frame_nxt = 1'b1;
      end else if (is_close) begin
        wr_en        = sts.close_ok;
        held_nxt     = '0;
        in_frame_nxt = 1'b0;
      end else if (in_frame_r && (held_r != HELD_MAX)) begin
        wr_en    = 1'b1;
        wr_data  = up_byte;
        held_nxt = held_r + IW'(1);
      end else begin
        held_nxt     = '0;
        in_frame_nxt = 1'b0;
      end
    end
  end

  // emit: read index and output valid
  always_comb begin
    rd_idx_nxt    = rd_idx_r;
    last_idx_nxt  = last_idx_r;
    out_valid_nxt = out_valid_r;
    if (cmd.start_emit) begin
      rd_idx_nxt   = '0;
      last_idx_nxt = held_r;
    end
    if (cmd.rd_en) begin
      rd_idx_nxt    = rd_idx_r + IW'(1);
      out_valid_nxt = 1'b1;
    end else if (cmd.out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= MIN_BODY_RST;
      in_frame_r  <= 1'b0;
      held_r      <= '0;
      rd_idx_r    <= '0;
      last_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        min_r <= cfg_wr_data;
      end
      in_frame_r  <= in_frame_nxt;
      held_r      <= held_nxt;
      rd_idx_r    <= rd_idx_nxt;
      last_idx_r  <= last_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read doubles as the output register; hold while stalled
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      out_byte_r <= mem[rd_idx_r];
      out_last_r <= rd_final;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

[hdl/bfd_ctrl.sv]
// Controller state machine: collect bytes, then stream out an accepted frame.
module bfd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  input  bfd_pkg::bfd_sts_t sts,
  output bfd_pkg::bfd_cmd_t cmd
);
  import bfd_pkg::*;

  bfd_state_t state_r, state_nxt;
  logic       advance;

  // read the next byte when the output register is empty or being drained
  assign advance = (state_r == ST_EMIT) && (!sts.out_valid || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_COLLECT: begin
        if (in_valid && sts.close_ok) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (advance && sts.rd_final) begin
          state_nxt = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_comb begin
    in_ready       = (state_r == ST_COLLECT);
    cmd.in_take    = in_ready && in_valid;
    cmd.start_emit = cmd.in_take && sts.close_ok;
    cmd.rd_en      = advance;
    cmd.out_pop    = sts.out_valid && out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/bracket_frame_deframer.sv]
// A closing bracket beat that completes a frame starts emission; the first frame byte is read
// once the output register is empty or being drained. Throughput: one received byte per cycle
// while collecting; an n-byte frame streams out at one byte per cycle, unless stalled, from a
// single-port frame store, input held off until its last byte is read. The last frame byte may
// wait in the output register while new bytes are collected. Reset (rst_n low, synchronous):
// frame closed, output empty, min_body_count = 13; the frame store keeps its contents.
module bracket_frame_deframer #(
  parameter int FRAME_BYTES = bfd_pkg::FRAME_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [bfd_pkg::MIN_W-1:0] cfg_wr_data,
  bfd_in_if.sink                    in_chan,
  bfd_out_if.source                 out_chan
);
  import bfd_pkg::*;

  bfd_cmd_t cmd;
  bfd_sts_t sts;

  bfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfd_datapath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_byte     (in_chan.rx_byte),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_chan.valid),
    .out_byte    (out_chan.frame_byte),
    .out_last    (out_chan.frame_last)
  );

endmodule

[hdl/bfd_checker.sv]
// Port-level checks for the bracket frame deframer, bound to the top level.
module bfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);
  import bfd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output beat changed");

  a_last_is_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_byte == CLOSE_BRACKET)
    else $error("last beat is not a closing bracket");

  a_body_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_byte != CLOSE_BRACKET &&
      (out_byte < LOWER_A || out_byte > LOWER_Z))
    else $error("frame body holds a closing bracket or lower-case letter");

  a_next_opens: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid && out_ready && out_last) && out_valid |-> out_byte == OPEN_BRACKET)
    else $error("frame does not start with an opening bracket");

endmodule

bind bracket_frame_deframer bfd_checker u_bfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_byte  (out_chan.frame_byte),
  .out_last  (out_chan.frame_last)
);
